>>> rtl/e2e_sm_pkg.sv
// Shared types, codes and sizes of the E2E window state machine.
package e2e_sm_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int WIN_IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int GRP_SIZE = 4;
	localparam int NUM_GRP = MAX_WINDOW / GRP_SIZE;
	localparam int PART_W = $clog2(GRP_SIZE + 1);
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int PS_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OK_INIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR_INIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OK_VALID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR_VALID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OK_INVALID  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR_INVALID = 3'd6;

	localparam logic [PS_W-1:0] PS_OK       = 3'd0;
	localparam logic [PS_W-1:0] PS_ERROR    = 3'd3;
	localparam logic [PS_W-1:0] PS_NOTAVAIL = 3'd4;
	localparam logic [PS_W-1:0] PS_NONEW    = 3'd5;

	localparam logic CMD_INIT = 1'b1;

	localparam logic RC_OK          = 1'b0;
	localparam logic RC_WRONG_STATE = 1'b1;

	typedef enum logic [2:0] {
		SM_DEINIT  = 3'd0,
		SM_NODATA  = 3'd1,
		SM_INIT    = 3'd2,
		SM_VALID   = 3'd3,
		SM_INVALID = 3'd4
	} sm_state_t;

	typedef struct packed {
		logic            init_win;
		logic            write_slot;
		logic            count_part;
		logic            count_sum;
		logic [PS_W-1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] ok_count;
		logic [CNT_W-1:0] err_count;
		logic             init_to_valid;
		logic             init_to_invalid;
		logic             valid_keep;
		logic             invalid_to_valid;
	} dp_stat_t;

endpackage

>>> rtl/e2e_sm_dp.sv
// Datapath: configuration registers, status window, index and window counts.
module e2e_sm_dp
	import e2e_sm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat
);

	logic [CFG_W-1:0] win_size_q;
	logic [CFG_W-1:0] min_ok_init_q;
	logic [CFG_W-1:0] max_err_init_q;
	logic [CFG_W-1:0] min_ok_valid_q;
	logic [CFG_W-1:0] max_err_valid_q;
	logic [CFG_W-1:0] min_ok_invalid_q;
	logic [CFG_W-1:0] max_err_invalid_q;

	logic [PS_W-1:0]      win_q [MAX_WINDOW];
	logic [WIN_IDX_W-1:0] index_q;
	logic [CNT_W-1:0]     ok_q;
	logic [CNT_W-1:0]     err_q;
	logic [PART_W-1:0]    ok_part_s1 [NUM_GRP];
	logic [PART_W-1:0]    err_part_s1 [NUM_GRP];

	logic [CNT_W-1:0]     used_n;
	logic [WIN_IDX_W-1:0] slot;
	logic [CNT_W-1:0]     slot_next;
	logic [PART_W-1:0]    ok_part_d [NUM_GRP];
	logic [PART_W-1:0]    err_part_d [NUM_GRP];
	logic [CNT_W-1:0]     ok_sum;
	logic [CNT_W-1:0]     err_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q        <= CFG_W'(MAX_WINDOW);
			min_ok_init_q     <= CFG_W'(1);
			max_err_init_q    <= '0;
			min_ok_valid_q    <= CFG_W'(1);
			max_err_valid_q   <= '0;
			min_ok_invalid_q  <= CFG_W'(1);
			max_err_invalid_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE:     win_size_q        <= cfg_data;
				REG_MIN_OK_INIT:     min_ok_init_q     <= cfg_data;
				REG_MAX_ERR_INIT:    max_err_init_q    <= cfg_data;
				REG_MIN_OK_VALID:    min_ok_valid_q    <= cfg_data;
				REG_MAX_ERR_VALID:   max_err_valid_q   <= cfg_data;
				REG_MIN_OK_INVALID:  min_ok_invalid_q  <= cfg_data;
				REG_MAX_ERR_INVALID: max_err_invalid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window size in use: zero counts as one, anything above the store as full.
	always_comb begin
		if (win_size_q == '0) begin
			used_n = CNT_W'(1);
		end else if (win_size_q > CFG_W'(MAX_WINDOW)) begin
			used_n = CNT_W'(MAX_WINDOW);
		end else begin
			used_n = win_size_q;
		end
	end

	// An index left beyond a shrunken window restarts at slot zero.
	assign slot = ({1'b0, index_q} >= used_n) ? '0 : index_q;
	assign slot_next = {1'b0, slot} + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				win_q[i] <= PS_NOTAVAIL;
			end
			index_q <= '0;
			ok_q    <= '0;
			err_q   <= '0;
		end else begin
			if (cmd.init_win) begin
				for (int i = 0; i < MAX_WINDOW; i++) begin
					if (CNT_W'(i) < used_n) begin
						win_q[i] <= PS_NOTAVAIL;
					end
				end
				index_q <= '0;
				ok_q    <= '0;
				err_q   <= '0;
			end else if (cmd.write_slot) begin
				win_q[slot] <= cmd.status;
				index_q     <= (slot_next >= used_n) ? '0 : slot_next[WIN_IDX_W-1:0];
			end else if (cmd.count_sum) begin
				ok_q  <= ok_sum;
				err_q <= err_sum;
			end
		end
	end

	// First stage of the count: OK and ERROR entries inside the window, per group.
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			ok_part_d[g]  = '0;
			err_part_d[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (CNT_W'(g * GRP_SIZE + j) < used_n) begin
					if (win_q[g * GRP_SIZE + j] == PS_OK) begin
						ok_part_d[g] = ok_part_d[g] + PART_W'(1);
					end else if (win_q[g * GRP_SIZE + j] == PS_ERROR) begin
						err_part_d[g] = err_part_d[g] + PART_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.count_part) begin
			for (int g = 0; g < NUM_GRP; g++) begin
				ok_part_s1[g]  <= ok_part_d[g];
				err_part_s1[g] <= err_part_d[g];
			end
		end
	end

	always_comb begin
		ok_sum  = '0;
		err_sum = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			ok_sum  = ok_sum + CNT_W'(ok_part_s1[g]);
			err_sum = err_sum + CNT_W'(err_part_s1[g]);
		end
	end

	assign stat.ok_count         = ok_q;
	assign stat.err_count        = err_q;
	assign stat.init_to_valid    = (err_sum <= max_err_init_q) && (ok_sum >= min_ok_init_q);
	assign stat.init_to_invalid  = (err_sum > max_err_init_q);
	assign stat.valid_keep       = (err_sum <= max_err_valid_q) && (ok_sum >= min_ok_valid_q);
	assign stat.invalid_to_valid = (err_sum <= max_err_invalid_q)
	                               && (ok_sum >= min_ok_invalid_q);

endmodule

>>> rtl/e2e_sm_ctrl.sv
// Controller: item sequencing, protocol state and the result register.
module e2e_sm_ctrl
	import e2e_sm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            command,
	input  logic [PS_W-1:0] profile_status,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            return_code,
	output logic [2:0]      machine_state,
	output logic [CNT_W-1:0] ok_total,
	output logic [CNT_W-1:0] error_total,
	output dp_cmd_t         dp_cmd,
	input  dp_stat_t        dp_stat
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_EXEC,
		PH_PART,
		PH_SUM,
		PH_RESULT
	} phase_t;

	phase_t          phase_q;
	sm_state_t       sm_q;
	logic            rc_q;
	logic            cmd_q;
	logic [PS_W-1:0] ps_q;
	logic            out_valid_q;
	logic            out_free;
	logic            checking;

	assign in_stall = (phase_q != PH_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign checking = (sm_q == SM_INIT) || (sm_q == SM_VALID) || (sm_q == SM_INVALID);

	always_comb begin
		dp_cmd.init_win   = (phase_q == PH_EXEC) && (cmd_q == CMD_INIT);
		dp_cmd.write_slot = (phase_q == PH_EXEC) && (cmd_q != CMD_INIT) && checking;
		dp_cmd.count_part = (phase_q == PH_PART);
		dp_cmd.count_sum  = (phase_q == PH_SUM);
		dp_cmd.status     = ps_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			sm_q          <= SM_DEINIT;
			rc_q          <= RC_OK;
			cmd_q         <= 1'b0;
			ps_q          <= '0;
			out_valid_q   <= 1'b0;
			return_code   <= RC_OK;
			machine_state <= SM_DEINIT;
			ok_total      <= '0;
			error_total   <= '0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (phase_q == PH_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (phase_q)
				PH_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						ps_q    <= profile_status;
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					if (cmd_q == CMD_INIT) begin
						rc_q    <= RC_OK;
						sm_q    <= SM_NODATA;
						phase_q <= PH_RESULT;
					end else begin
						case (sm_q)
							SM_DEINIT: begin
								rc_q    <= RC_WRONG_STATE;
								phase_q <= PH_RESULT;
							end
							SM_NODATA: begin
								rc_q    <= RC_OK;
								phase_q <= PH_RESULT;
								if (ps_q != PS_ERROR && ps_q != PS_NONEW) begin
									sm_q <= SM_INIT;
								end
							end
							default: begin
								rc_q    <= RC_OK;
								phase_q <= PH_PART;
							end
						endcase
					end
				end
				PH_PART: phase_q <= PH_SUM;
				PH_SUM: begin
					phase_q <= PH_RESULT;
					case (sm_q)
						SM_INIT: begin
							if (dp_stat.init_to_valid) begin
								sm_q <= SM_VALID;
							end else if (dp_stat.init_to_invalid) begin
								sm_q <= SM_INVALID;
							end
						end
						SM_VALID: begin
							if (!dp_stat.valid_keep) begin
								sm_q <= SM_INVALID;
							end
						end
						SM_INVALID: begin
							if (dp_stat.invalid_to_valid) begin
								sm_q <= SM_VALID;
							end
						end
						default: ;
					endcase
				end
				PH_RESULT: begin
					if (out_free) begin
						return_code   <= rc_q;
						machine_state <= sm_q;
						ok_total      <= dp_stat.ok_count;
						error_total   <= dp_stat.err_count;
						phase_q       <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/e2e_window_state_machine.sv
// Top level of the E2E window state machine: controller and datapath.
//
// One item per received message: an init command, or a check that carries a
// profile status. An accepted check that is recorded in the window writes the
// slot, counts the window in four registered groups, adds the groups and
// applies the thresholds of the current state, and loads the result register.
// An init, a check before init and a check in NODATA skip the counting. No new
// item is taken before the last has loaded the result register, which parts
// the output from the input, so an item is taken while the previous result
// still waits. The user must write configuration through cfg_we, cfg_index
// and cfg_data only while the block is idle, which the block does not enforce;
// reset restores the documented defaults at once, with no clearing pass.
module e2e_window_state_machine
	import e2e_sm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [PS_W-1:0]      profile_status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 return_code,
	output logic [2:0]           machine_state,
	output logic [CNT_W-1:0]     ok_total,
	output logic [CNT_W-1:0]     error_total
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	e2e_sm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.profile_status (profile_status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.return_code    (return_code),
		.machine_state  (machine_state),
		.ok_total       (ok_total),
		.error_total    (error_total),
		.dp_cmd         (dp_cmd),
		.dp_stat        (dp_stat)
	);

	e2e_sm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

endmodule

>>> bench/testbench.sv
// Self-checking bench for the E2E window state machine: directed and random items against a built-in predictor.
module testbench;
	import e2e_sm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 175;
	localparam int MAX_REPORTS   = 40;

	localparam logic            CMD_CHECK   = 1'b0;
	localparam logic [PS_W-1:0] PS_REPEATED = 3'd1;
	localparam logic [PS_W-1:0] PS_WRONGSEQ = 3'd2;
	localparam logic [PS_W-1:0] PS_SPARE6   = 3'd6;
	localparam logic [PS_W-1:0] PS_SPARE7   = 3'd7;

	typedef struct packed {
		logic            cmd;
		logic [PS_W-1:0] ps;
	} msg_item_t;

	typedef struct packed {
		logic             rc;
		sm_state_t        sm;
		logic [CNT_W-1:0] oks;
		logic [CNT_W-1:0] errs;
	} sm_result_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = REG_WINDOW_SIZE;
	logic [CFG_W-1:0]     cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic                 command        = CMD_CHECK;
	logic [PS_W-1:0]      profile_status = PS_OK;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic                 return_code;
	logic [2:0]           machine_state;
	logic [CNT_W-1:0]     ok_total;
	logic [CNT_W-1:0]     error_total;

	// Predictor state: a private copy of the registers, the window and the machine.
	logic [CFG_W-1:0] cfg_mirror [0:7];
	logic [PS_W-1:0]  win_slots [MAX_WINDOW];
	int unsigned      win_pos;
	logic [CNT_W-1:0] ok_tally;
	logic [CNT_W-1:0] err_tally;
	sm_state_t        sm_now;

	msg_item_t  pending_items [$];
	sm_result_t sm_outcomes [$];
	sm_result_t due;
	msg_item_t  nxt;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatches  = 0;
	int items_taken = 0;
	int results_seen = 0;
	int settings_used = 1;
	int state_hits [8];

	e2e_window_state_machine i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.profile_status (profile_status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.return_code    (return_code),
		.machine_state  (machine_state),
		.ok_total       (ok_total),
		.error_total    (error_total)
	);

	always #(CLK_HALF) clk = ~clk;

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	// Writes the status into the window and recounts the slots in use.
	function automatic void log_status(logic [PS_W-1:0] ps, int unsigned span);
		int unsigned slot;
		slot = (win_pos >= span) ? 0 : win_pos;
		win_slots[slot] = ps;
		ok_tally = '0;
		err_tally = '0;
		for (int i = 0; i < span; i++) begin
			if (win_slots[i] == PS_OK) begin
				ok_tally++;
			end else if (win_slots[i] == PS_ERROR) begin
				err_tally++;
			end
		end
		win_pos = (slot + 1 >= span) ? 0 : slot + 1;
	endfunction

	function automatic sm_result_t step_window_machine(logic cmd, logic [PS_W-1:0] ps);
		sm_result_t  r;
		int unsigned span;
		span = cfg_mirror[REG_WINDOW_SIZE];
		if (span == 0) begin
			span = 1;
		end else if (span > MAX_WINDOW) begin
			span = MAX_WINDOW;
		end
		r.rc = RC_OK;
		if (cmd == CMD_INIT) begin
			// Slots beyond the size in use keep whatever they held.
			for (int i = 0; i < span; i++) begin
				win_slots[i] = PS_NOTAVAIL;
			end
			win_pos = 0;
			ok_tally = '0;
			err_tally = '0;
			sm_now = SM_NODATA;
		end else begin
			case (sm_now)
				SM_NODATA: begin
					if (ps != PS_ERROR && ps != PS_NONEW) begin
						sm_now = SM_INIT;
					end
				end
				SM_INIT: begin
					log_status(ps, span);
					if (err_tally <= cfg_mirror[REG_MAX_ERR_INIT] &&
					    ok_tally >= cfg_mirror[REG_MIN_OK_INIT]) begin
						sm_now = SM_VALID;
					end else if (err_tally > cfg_mirror[REG_MAX_ERR_INIT]) begin
						sm_now = SM_INVALID;
					end
				end
				SM_VALID: begin
					log_status(ps, span);
					if (!(err_tally <= cfg_mirror[REG_MAX_ERR_VALID] &&
					      ok_tally >= cfg_mirror[REG_MIN_OK_VALID])) begin
						sm_now = SM_INVALID;
					end
				end
				SM_INVALID: begin
					log_status(ps, span);
					if (err_tally <= cfg_mirror[REG_MAX_ERR_INVALID] &&
					    ok_tally >= cfg_mirror[REG_MIN_OK_INVALID]) begin
						sm_now = SM_VALID;
					end
				end
				default: begin
					r.rc = RC_WRONG_STATE;
				end
			endcase
		end
		r.sm = sm_now;
		r.oks = ok_tally;
		r.errs = err_tally;
		return r;
	endfunction

	task automatic queue_item(logic cmd, logic [PS_W-1:0] ps);
		msg_item_t m;
		m.cmd = cmd;
		m.ps = ps;
		pending_items.push_back(m);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		cfg_mirror[idx] = CFG_W'(val);
	endtask

	task automatic apply_setting(int ws, int moi, int mei, int mov, int mev, int mon, int men);
		write_reg(REG_WINDOW_SIZE, ws);
		write_reg(REG_MIN_OK_INIT, moi);
		write_reg(REG_MAX_ERR_INIT, mei);
		write_reg(REG_MIN_OK_VALID, mov);
		write_reg(REG_MAX_ERR_VALID, mev);
		write_reg(REG_MIN_OK_INVALID, mon);
		write_reg(REG_MAX_ERR_INVALID, men);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_for_drain();
		while (pending_items.size() != 0 || in_valid || sm_outcomes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Sender: the item on offer is predicted at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_CHECK;
			profile_status <= PS_OK;
		end else begin
			if (in_valid && !in_stall) begin
				sm_outcomes.push_back(step_window_machine(command, profile_status));
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					nxt = pending_items.pop_front();
					in_valid <= 1'b1;
					command <= nxt.cmd;
					profile_status <= nxt.ps;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (sm_outcomes.size() == 0) begin
					flag_mismatch("result with nothing outstanding", 1, 0);
				end else begin
					due = sm_outcomes.pop_front();
					state_hits[due.sm]++;
					if (return_code !== due.rc) begin
						flag_mismatch("return_code", return_code, due.rc);
					end
					if (machine_state !== due.sm) begin
						flag_mismatch("machine_state", machine_state, due.sm);
					end
					if (ok_total !== due.oks) begin
						flag_mismatch("ok_total", ok_total, due.oks);
					end
					if (error_total !== due.errs) begin
						flag_mismatch("error_total", error_total, due.errs);
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	initial begin
		int r;
		int ok_bias;
		int err_bias;
		int span;
		logic [PS_W-1:0] ps;

		cfg_mirror[REG_WINDOW_SIZE] = 5'd16;
		cfg_mirror[REG_MIN_OK_INIT] = 5'd1;
		cfg_mirror[REG_MAX_ERR_INIT] = 5'd0;
		cfg_mirror[REG_MIN_OK_VALID] = 5'd1;
		cfg_mirror[REG_MAX_ERR_VALID] = 5'd0;
		cfg_mirror[REG_MIN_OK_INVALID] = 5'd1;
		cfg_mirror[REG_MAX_ERR_INVALID] = 5'd0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			win_slots[i] = PS_NOTAVAIL;
		end
		win_pos = 0;
		ok_tally = '0;
		err_tally = '0;
		sm_now = SM_DEINIT;
		foreach (state_hits[i]) state_hits[i] = 0;

		tx_idle_pct = 6;
		rx_idle_pct = 82;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening under the reset settings: checks before init, the
		// NODATA exits, unknown status codes and every state transition but INVALID to VALID.
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_SPARE7);
		queue_item(CMD_INIT, PS_SPARE7);
		queue_item(CMD_CHECK, PS_ERROR);
		queue_item(CMD_CHECK, PS_NONEW);
		queue_item(CMD_CHECK, PS_SPARE6);
		queue_item(CMD_CHECK, PS_REPEATED);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_WRONGSEQ);
		queue_item(CMD_CHECK, PS_SPARE7);
		queue_item(CMD_CHECK, PS_ERROR);
		queue_item(CMD_CHECK, PS_NOTAVAIL);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_INIT, PS_OK);
		queue_item(CMD_CHECK, PS_NOTAVAIL);
		queue_item(CMD_CHECK, PS_ERROR);
		queue_item(CMD_INIT, PS_ERROR);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_OK);
		queue_item(CMD_CHECK, PS_SPARE6);
		queue_item(CMD_CHECK, PS_NONEW);
		queue_item(CMD_CHECK, PS_OK);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Every phase boundary holds the sender until the block is empty.
			wait_for_drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (p < 4) begin
				tx_idle_pct = 6;
				rx_idle_pct = 82;
			end else if (p < 7) begin
				tx_idle_pct = 82;
				rx_idle_pct = 6;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (p)
				0: apply_setting(4, 2, 1, 3, 1, 2, 0);
				1: apply_setting(0, 0, 0, 0, 0, 0, 0);
				2: apply_setting(31, 16, 16, 16, 16, 16, 16);
				3: apply_setting(16, 31, 31, 31, 31, 31, 31);
				4: apply_setting(1, 1, 0, 1, 0, 1, 0);
				5: apply_setting(16, 16, 0, 16, 0, 8, 2);
				default: begin
					span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
					                                  : $urandom_range(1, 16);
					r = (span == 0) ? 1 : (span > MAX_WINDOW) ? MAX_WINDOW : span;
					apply_setting(span, $urandom_range(0, r + 1), $urandom_range(0, r / 2 + 1),
					              $urandom_range(0, r + 1), $urandom_range(0, r / 2 + 1),
					              $urandom_range(0, r + 1), $urandom_range(0, r / 2 + 1));
				end
			endcase
			// Without a fresh init the old index may lie beyond a shrunken window.
			if ($urandom_range(0, 1) == 1) begin
				queue_item(CMD_INIT, PS_W'($urandom_range(0, 7)));
			end
			ok_bias = $urandom_range(30, 95);
			err_bias = $urandom_range(0, 100 - ok_bias);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					queue_item(CMD_INIT, PS_W'($urandom_range(0, 7)));
				end else begin
					r = $urandom_range(0, 99);
					if (r < ok_bias) begin
						ps = PS_OK;
					end else if (r < ok_bias + err_bias) begin
						ps = PS_ERROR;
					end else begin
						ps = PS_W'($urandom_range(0, 7));
					end
					queue_item(CMD_CHECK, ps);
				end
			end
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sm_outcomes.size() != 0) begin
			flag_mismatch("results never delivered", 0, sm_outcomes.size());
		end
		$display("Run covered %0d items and %0d results under %0d register settings.",
		         items_taken, results_seen, settings_used);
		$display("Results by state deinit/nodata/init/valid/invalid: %0d/%0d/%0d/%0d/%0d.",
		         state_hits[SM_DEINIT], state_hits[SM_NODATA], state_hits[SM_INIT],
		         state_hits[SM_VALID], state_hits[SM_INVALID]);
		if (mismatches == 0) begin
			$display("** e2e_window_state_machine: PASSED **");
		end else begin
			$display("** e2e_window_state_machine: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Run did not complete in time.");
		$display("** e2e_window_state_machine: FAILED **");
		$finish;
	end

endmodule
